@@ hdl/stsc_pkg.sv @@
// Shared constants, types and the slot hash of the subarray target sum counter.
`default_nettype none

package stsc_pkg;

	// Array and table dimensions.
	localparam int MAX_LEN     = 1024;
	localparam int TABLE_SIZE  = 2048;  // power of two: probing wraps by carry
	localparam int VALUE_BITS  = 16;    // significant bits of an element

	// Field widths fixed by the interface.
	localparam int ELEM_BITS   = 16;
	localparam int TARGET_BITS = 27;
	localparam int SUM_BITS    = 27;
	localparam int DIFF_BITS   = SUM_BITS + 1;
	localparam int COUNT_BITS  = 20;
	localparam int TALLY_BITS  = 11;

	// Derived sizes.
	localparam int LEN_BITS    = $clog2(MAX_LEN + 1);
	localparam int TBL_AW      = $clog2(TABLE_SIZE);
	localparam int OCC_BITS    = $clog2(TABLE_SIZE + 1);
	localparam int EPOCH_BITS  = 8;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [TALLY_BITS-1:0] TALLY_MAX = '1;

	// One classified element on its way from the front to the back.
	typedef struct packed {
		logic                        active;      // within the first MAX_LEN elements
		logic                        last;
		logic signed [DIFF_BITS-1:0] lookup_key;  // prefix sum minus target
		logic signed [SUM_BITS-1:0]  record_key;  // new prefix sum
	} stsc_item_t;

	// One hash table entry; it is live only when its epoch is the current one.
	typedef struct packed {
		logic [EPOCH_BITS-1:0] epoch;
		logic [SUM_BITS-1:0]   key;
		logic [TALLY_BITS-1:0] tally;
	} stsc_entry_t;

	localparam int ENTRY_BITS = $bits(stsc_entry_t);

	// Status of the back end as seen by the front end.
	typedef struct packed {
		logic clearing;
		logic idle;
	} stsc_back_stat_t;

	// XOR fold of the key onto the table address.
	function automatic logic [TBL_AW-1:0] slot_hash(input logic [SUM_BITS-1:0] key);
		logic [TBL_AW-1:0] h;
		h = '0;
		for (int i = 0; i < SUM_BITS; i++) begin
			h[i % TBL_AW] = h[i % TBL_AW] ^ key[i];
		end
		return h;
	endfunction

endpackage

`default_nettype wire

@@ hdl/stsc_elem_if.sv @@
// Element channel: one signed array element and its last mark per item.
`default_nettype none

interface stsc_elem_if import stsc_pkg::*;;
	logic                        valid;
	logic                        ready;
	logic signed [ELEM_BITS-1:0] element_value;
	logic                        is_last;

	modport source (output valid, output element_value, output is_last, input ready);
	modport sink   (input valid, input element_value, input is_last, output ready);
endinterface

`default_nettype wire

@@ hdl/stsc_result_if.sv @@
// Result channel: the subarray count of one array and its overflow flag.
`default_nettype none

interface stsc_result_if import stsc_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [COUNT_BITS-1:0] subarray_count;
	logic                  length_overflow;

	modport source (output valid, output subarray_count, output length_overflow, input ready);
	modport sink   (input valid, input subarray_count, input length_overflow, output ready);
endinterface

`default_nettype wire

@@ hdl/stsc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module stsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ hdl/stsc_front.sv @@
// Front end: holds the target, accepts elements, tracks the prefix sum and classifies items.
`default_nettype none

module stsc_front import stsc_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	stsc_elem_if.sink                     elem_chan,
	input  logic                          cfg_valid,
	input  logic signed [TARGET_BITS-1:0] target_sum,
	input  logic                          q_full,
	input  stsc_back_stat_t               back_stat,
	output logic                          q_push,
	output stsc_item_t                    q_item
);

	logic signed [TARGET_BITS-1:0] target_q;
	logic signed [SUM_BITS-1:0]    prefix_q;
	logic [LEN_BITS-1:0]           count_q;

	logic signed [VALUE_BITS-1:0]  elem_raw;
	logic signed [SUM_BITS-1:0]    elem_sx;
	logic signed [SUM_BITS-1:0]    prefix_next;
	logic                          active;

	assign elem_raw    = elem_chan.element_value[VALUE_BITS-1:0];
	assign elem_sx     = SUM_BITS'(elem_raw);
	assign prefix_next = prefix_q + elem_sx;
	assign active      = count_q < LEN_BITS'(MAX_LEN);

	// No item enters while the table is being swept.
	assign elem_chan.ready = !q_full && !back_stat.clearing;
	assign q_push          = elem_chan.valid && elem_chan.ready;

	always_comb begin
		q_item.active     = active;
		q_item.last       = elem_chan.is_last;
		q_item.lookup_key = DIFF_BITS'(prefix_next) - DIFF_BITS'(target_q);
		q_item.record_key = prefix_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			prefix_q <= '0;
			count_q  <= '0;
		end else begin
			if (cfg_valid) begin
				target_q <= target_sum;
			end
			if (q_push) begin
				if (elem_chan.is_last) begin
					prefix_q <= '0;
					count_q  <= '0;
				end else if (active) begin
					prefix_q <= prefix_next;
					count_q  <= count_q + 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/stsc_queue.sv @@
// Short item queue between the front end and the back end.
`default_nettype none

module stsc_queue import stsc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  stsc_item_t item_in,
	input  logic       pop,
	output stsc_item_t head,
	output logic       full,
	output logic       empty
);

	localparam int QA = $clog2(QUEUE_DEPTH);
	localparam int QC = $clog2(QUEUE_DEPTH + 1);

	stsc_item_t     slot_q [QUEUE_DEPTH];
	logic [QA-1:0]  wr_ptr_q;
	logic [QA-1:0]  rd_ptr_q;
	logic [QC-1:0]  count_q;

	assign full  = count_q == QC'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QA'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QA'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/stsc_back.sv @@
// Back end: hash table lookup and update, match total, table sweep and result register.
`default_nettype none

module stsc_back import stsc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  stsc_item_t      q_head,
	output logic            q_pop,
	output stsc_back_stat_t stat,
	stsc_result_if.source   result_chan
);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_LOOKUP = 3'd2;
	localparam logic [2:0] ST_RECORD = 3'd3;
	localparam logic [2:0] ST_EMIT   = 3'd4;

	logic [2:0]            state_q, state_d;
	stsc_item_t            item_q, item_d;
	logic [TBL_AW-1:0]     probe_addr_q;
	logic [TBL_AW-1:0]     clr_addr_q, clr_addr_d;
	logic [COUNT_BITS-1:0] match_q, match_d;
	logic                  ovf_q, ovf_d;
	logic [TALLY_BITS-1:0] zero_tally_q, zero_tally_d;
	logic [OCC_BITS-1:0]   occupied_q, occupied_d;
	logic [EPOCH_BITS-1:0] epoch_q, epoch_d;
	logic                  res_valid_q, res_valid_d;
	logic                  res_load;
	logic [COUNT_BITS-1:0] res_count_q;
	logic                  res_ovf_q;

	logic [TBL_AW-1:0]     rd_addr;
	logic                  ram_we;
	logic [TBL_AW-1:0]     wr_addr;
	stsc_entry_t           wr_data;
	logic [ENTRY_BITS-1:0] rd_raw;
	stsc_entry_t           ent;

	logic                  ent_live, lk_hit, rec_hit;
	logic                  head_lk_zero, head_lk_far, head_rec_zero;
	logic                  res_free;
	logic [TALLY_BITS-1:0] zero_inc, ent_inc, add_tally;
	logic [COUNT_BITS:0]   match_sum;
	logic [COUNT_BITS-1:0] match_sat;

	stsc_ram #(
		.WIDTH (ENTRY_BITS),
		.DEPTH (TABLE_SIZE)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_raw)
	);

	// Read data always belongs to the address presented in the previous cycle.
	assign ent      = stsc_entry_t'(rd_raw);
	assign ent_live = ent.epoch == epoch_q;
	assign lk_hit   = ent_live && (ent.key == item_q.lookup_key[SUM_BITS-1:0]);
	assign rec_hit  = ent_live && (ent.key == item_q.record_key);

	assign head_lk_zero  = q_head.lookup_key == '0;
	assign head_lk_far   = q_head.lookup_key[DIFF_BITS-1] != q_head.lookup_key[DIFF_BITS-2];
	assign head_rec_zero = q_head.record_key == '0;

	assign res_free = !res_valid_q || result_chan.ready;
	assign zero_inc = (zero_tally_q == TALLY_MAX) ? zero_tally_q : zero_tally_q + 1'b1;
	assign ent_inc  = (ent.tally == TALLY_MAX) ? ent.tally : ent.tally + 1'b1;

	assign match_sum = {1'b0, match_q} + (COUNT_BITS + 1)'(add_tally);
	assign match_sat = match_sum[COUNT_BITS] ? COUNT_MAX : match_sum[COUNT_BITS-1:0];

	always_comb begin
		state_d      = state_q;
		item_d       = item_q;
		clr_addr_d   = clr_addr_q;
		match_d      = match_q;
		ovf_d        = ovf_q;
		zero_tally_d = zero_tally_q;
		occupied_d   = occupied_q;
		epoch_d      = epoch_q;
		res_valid_d  = res_valid_q && !result_chan.ready;
		res_load     = 1'b0;
		q_pop        = 1'b0;
		add_tally    = '0;
		rd_addr      = probe_addr_q;
		ram_we       = 1'b0;
		wr_addr      = probe_addr_q;
		wr_data      = '{epoch: epoch_q, key: item_q.record_key, tally: TALLY_BITS'(1)};

		unique case (state_q)
			ST_CLEAR: begin
				ram_we     = 1'b1;
				wr_addr    = clr_addr_q;
				wr_data    = '0;
				clr_addr_d = clr_addr_q + 1'b1;
				if (clr_addr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (!q_empty) begin
					q_pop  = 1'b1;
					item_d = q_head;
					if (!q_head.active) begin
						ovf_d   = 1'b1;
						state_d = q_head.last ? ST_EMIT : ST_IDLE;
					end else if (head_lk_zero || head_lk_far) begin
						// Key zero lives in its own counter; a key outside the
						// prefix range can never match.
						if (head_lk_zero) begin
							add_tally = zero_tally_q;
						end
						match_d = match_sat;
						if (head_rec_zero) begin
							zero_tally_d = zero_inc;
							state_d      = q_head.last ? ST_EMIT : ST_IDLE;
						end else begin
							rd_addr = slot_hash(q_head.record_key);
							state_d = ST_RECORD;
						end
					end else begin
						rd_addr = slot_hash(q_head.lookup_key[SUM_BITS-1:0]);
						state_d = ST_LOOKUP;
					end
				end
			end
			ST_LOOKUP: begin
				if (!ent_live || lk_hit) begin
					if (lk_hit) begin
						add_tally = ent.tally;
					end
					match_d = match_sat;
					if (item_q.record_key == '0) begin
						zero_tally_d = zero_inc;
						state_d      = item_q.last ? ST_EMIT : ST_IDLE;
					end else begin
						rd_addr = slot_hash(item_q.record_key);
						state_d = ST_RECORD;
					end
				end else begin
					rd_addr = probe_addr_q + 1'b1;
				end
			end
			ST_RECORD: begin
				if (!ent_live) begin
					// The seed counts as one occupied entry.
					if (occupied_q == OCC_BITS'(TABLE_SIZE)) begin
						ovf_d = 1'b1;
					end else begin
						ram_we     = 1'b1;
						occupied_d = occupied_q + 1'b1;
					end
					state_d = item_q.last ? ST_EMIT : ST_IDLE;
				end else if (rec_hit) begin
					ram_we        = 1'b1;
					wr_data.tally = ent_inc;
					state_d       = item_q.last ? ST_EMIT : ST_IDLE;
				end else begin
					rd_addr = probe_addr_q + 1'b1;
				end
			end
			ST_EMIT: begin
				if (res_free) begin
					res_load     = 1'b1;
					res_valid_d  = 1'b1;
					match_d      = '0;
					ovf_d        = 1'b0;
					zero_tally_d = TALLY_BITS'(1);
					occupied_d   = OCC_BITS'(1);
					// A new epoch retires every entry at once; on wrap the
					// old marks must be swept away first.
					if (epoch_q == '1) begin
						epoch_d    = EPOCH_BITS'(1);
						clr_addr_d = '0;
						state_d    = ST_CLEAR;
					end else begin
						epoch_d = epoch_q + 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		probe_addr_q <= rd_addr;
		item_q       <= item_d;
		if (res_load) begin
			res_count_q <= match_q;
			res_ovf_q   <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_addr_q   <= '0;
			match_q      <= '0;
			ovf_q        <= 1'b0;
			zero_tally_q <= TALLY_BITS'(1);
			occupied_q   <= OCC_BITS'(1);
			epoch_q      <= EPOCH_BITS'(1);
			res_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			clr_addr_q   <= clr_addr_d;
			match_q      <= match_d;
			ovf_q        <= ovf_d;
			zero_tally_q <= zero_tally_d;
			occupied_q   <= occupied_d;
			epoch_q      <= epoch_d;
			res_valid_q  <= res_valid_d;
		end
	end

	assign stat.clearing = state_q == ST_CLEAR;
	assign stat.idle     = state_q == ST_IDLE;

	assign result_chan.valid           = res_valid_q;
	assign result_chan.subarray_count  = res_count_q;
	assign result_chan.length_overflow = res_ovf_q;

endmodule

`default_nettype wire

@@ hdl/subarray_target_sum_counter.sv @@
// Top level of the subarray target sum counter: front end, item queue and back end.
`default_nettype none

// Counts the contiguous subarrays of one array whose elements sum to target_sum.
// The array arrives on elem_chan, one signed element per item, the final element
// marked by is_last. For that final element one item leaves on result_chan with
// the count (saturating at 2^20-1) and a flag for an array longer than 1024
// elements or a full table; elements beyond 1024 are ignored.
// target_sum is written through cfg_valid, which is always ready; write it only
// while no array is in progress.
// The front end takes an element in the cycle it is offered whenever the
// four-deep queue has room and no sweep runs. The back end takes an item from
// the queue while idle, then probes the prefix sum hash table for the lookup and
// again for the update, probing on to the next slot on a collision; a lookup of
// sum zero or of a value outside the prefix range skips its probe, a new prefix
// sum of zero skips the update probe, and an element past the length limit takes
// no probe. The table has a single read port, so the probes run one after
// another. The back end loads the result register after the last element is
// through, once the previous result has been taken.
// After reset, and after every 255th array, the back end sweeps all 2048 table
// entries, one per cycle, and elem_chan is not ready meanwhile.
// The result sits in an output register; while the receiver stalls, elements
// keep flowing until the next result is due.

module subarray_target_sum_counter import stsc_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	stsc_elem_if.sink                     elem_chan,
	stsc_result_if.source                 result_chan,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic signed [TARGET_BITS-1:0] target_sum
);

	logic            q_push;
	logic            q_pop;
	logic            q_full;
	logic            q_empty;
	stsc_item_t      q_item;
	stsc_item_t      q_head;
	stsc_back_stat_t back_stat;

	assign cfg_ready = 1'b1;

	stsc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.elem_chan  (elem_chan),
		.cfg_valid  (cfg_valid),
		.target_sum (target_sum),
		.q_full     (q_full),
		.back_stat  (back_stat),
		.q_push     (q_push),
		.q_item     (q_item)
	);

	stsc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.item_in (q_item),
		.pop     (q_pop),
		.head    (q_head),
		.full    (q_full),
		.empty   (q_empty)
	);

	stsc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.stat        (back_stat),
		.result_chan (result_chan)
	);

`ifndef NO_ASSERTIONS
	// No element may slip in while the table sweep is running.
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.clearing |-> !(elem_chan.valid && elem_chan.ready))
		else $error("element accepted during table sweep");

	// The front end never pushes into a full queue.
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("push into full queue");

	// The back end only takes items that exist, and only while idle.
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty && back_stat.idle)
		else $error("pop from empty queue or outside idle");
`endif

endmodule

`default_nettype wire
